// File: rtl/vwmp_pkg.sv
// shared types and constants for the variable-width mantissa packer
package vwmp_pkg;

  // word and field widths
  localparam int WORD_BITS = 16;
  localparam int SIZE_W    = 5;
  localparam int TOTAL_W   = 14;
  localparam int BYTES_W   = 11;

  localparam logic [SIZE_W-1:0]  SIZE_MAX  = SIZE_W'(WORD_BITS);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

  // stream packing
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // what the back end has to do with an item
  typedef enum logic [1:0] {
    KIND_ABSENT,
    KIND_BIN,
    KIND_FLUSH
  } kind_t;

  // classified item
  typedef struct packed {
    kind_t                  kind;
    logic [WORD_BITS-1:0]   mant;
    logic [SIZE_W-1:0]      size;
  } item_t;

  // one result
  typedef struct packed {
    logic                   present;
    logic                   word_valid;
    logic [WORD_BITS-1:0]   packed_word;
    logic                   frame_done;
    logic [BYTES_W-1:0]     byte_count;
  } result_t;

endpackage

// File: rtl/variable_width_mantissa_packer.sv
// top level of the variable-width mantissa packer
// Packs one spectral bin per beat: the front end clamps the bit size, marks
// zero bins absent and queues the beat; the back end ORs the mantissa into a
// 16-bit word at the current bit pointer, ships the word when the next bin
// would overflow it, and on a tlast beat ships the partial word with the
// frame byte count and clears its state. One beat in and one beat out per
// clock while out_tready stays high; an input beat is written into the
// four-entry queue and then into the output register. Each input beat
// gives exactly one output beat. The queue lets the input keep flowing for
// four beats while the output is stalled.
module variable_width_mantissa_packer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] mantissa_high, [20:16] bit_size, [23:21] zero
  input  logic [vwmp_pkg::IN_DATA_W-1:0]  in_tdata,
  // frame_end
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] packed_word, [26:16] byte_count, [31:27] zero
  output logic [vwmp_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] present, [1] word_valid
  output logic [vwmp_pkg::OUT_USER_W-1:0] out_tuser,
  // frame_done
  output logic                            out_tlast
);
  import vwmp_pkg::*;

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_not_empty;
  item_t q_item;
  item_t q_head;

  // classify incoming beats
  vwmp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  // decoupling queue
  vwmp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // pack and ship
  vwmp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// File: rtl/vwmp_front.sv
// front end: input handshake, size clamp and bin classification
module vwmp_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [vwmp_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tlast,
  input  logic                           q_full,
  output logic                           q_push,
  output vwmp_pkg::item_t                q_item
);
  import vwmp_pkg::*;

  logic [WORD_BITS-1:0] mant;
  logic [SIZE_W-1:0]    size_raw;
  logic [SIZE_W-1:0]    size_clamped;

  // unpack the beat
  assign mant     = in_tdata[WORD_BITS-1:0];
  assign size_raw = in_tdata[WORD_BITS+SIZE_W-1:WORD_BITS];

  // accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // clamp oversized widths to a full word
  assign size_clamped = (size_raw > SIZE_MAX) ? SIZE_MAX : size_raw;

  // classify the bin
  always_comb begin
    q_item.mant = mant;
    q_item.size = size_clamped;
    if (in_tlast) begin
      q_item.kind = KIND_FLUSH;
    end else if (mant == '0 || size_raw == '0) begin
      q_item.kind = KIND_ABSENT;
    end else begin
      q_item.kind = KIND_BIN;
    end
  end

endmodule

// File: rtl/vwmp_queue.sv
// short queue of classified items between front and back
module vwmp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vwmp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output vwmp_pkg::item_t head
);
  import vwmp_pkg::*;

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/vwmp_back.sv
// back end: shift-or packing, word shipping, frame flush and output register
module vwmp_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_not_empty,
  input  vwmp_pkg::item_t                 q_head,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [vwmp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [vwmp_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                            out_tlast
);
  import vwmp_pkg::*;

  logic [SIZE_W-1:0]    ptr_r, ptr_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [TOTAL_W-1:0]   tbits_r, tbits_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              res_r, res_nxt;

  logic [SIZE_W:0]      right;
  logic                 ship;
  logic [TOTAL_W:0]     tbits_sum;
  logic [TOTAL_W:0]     bytes_full;
  logic [SIZE_W-1:0]    left;
  logic [WORD_BITS-1:0] base;

  // take the next item when the output register is free or draining
  assign q_pop = q_not_empty && (!out_valid_r || out_tready);

  // datapath pieces
  assign right      = {1'b0, ptr_r} + {1'b0, q_head.size};
  assign ship       = (right > (SIZE_W+1)'(WORD_BITS));
  assign tbits_sum  = {1'b0, tbits_r} + (TOTAL_W+1)'(q_head.size);
  assign bytes_full = ({1'b0, tbits_r} + (TOTAL_W+1)'(7)) >> 3;
  assign left       = ship ? '0 : ptr_r;
  assign base       = ship ? '0 : acc_r;

  // packing state and result
  always_comb begin
    ptr_nxt       = ptr_r;
    acc_nxt       = acc_r;
    tbits_nxt     = tbits_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      unique case (q_head.kind)
        KIND_FLUSH: begin
          res_nxt.word_valid  = 1'b1;
          res_nxt.packed_word = acc_r;
          res_nxt.frame_done  = 1'b1;
          res_nxt.byte_count  = (bytes_full > (TOTAL_W+1)'(BYTES_MAX)) ?
                                BYTES_MAX : bytes_full[BYTES_W-1:0];
          ptr_nxt   = '0;
          acc_nxt   = '0;
          tbits_nxt = '0;
        end
        KIND_BIN: begin
          res_nxt.present = 1'b1;
          if (ship) begin
            res_nxt.word_valid  = 1'b1;
            res_nxt.packed_word = acc_r;
          end
          acc_nxt   = base | (q_head.mant >> left);
          ptr_nxt   = ship ? q_head.size : right[SIZE_W-1:0];
          tbits_nxt = (tbits_sum > (TOTAL_W+1)'(TOTAL_MAX)) ?
                      TOTAL_MAX : tbits_sum[TOTAL_W-1:0];
        end
        default: begin
          // absent bin: empty result, state untouched
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      acc_r       <= '0;
      tbits_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      acc_r       <= acc_nxt;
      tbits_r     <= tbits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // output beat
  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.frame_done;
  assign out_tuser  = {res_r.word_valid, res_r.present};
  assign out_tdata  = {{(OUT_DATA_W-WORD_BITS-BYTES_W){1'b0}},
                       res_r.byte_count, res_r.packed_word};

  // bit pointer never runs past the word
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= SIZE_MAX)
    else $error("bit pointer beyond word");

  // a flush leaves the frame state cleared
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head.kind == KIND_FLUSH |=> ptr_r == '0 && acc_r == '0 && tbits_r == '0)
    else $error("flush did not clear state");

  // frame results always carry the partial word and no bin
  a_done_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.frame_done |-> res_r.word_valid && !res_r.present)
    else $error("frame result malformed");

  // absent bins never ship a word
  a_absent_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head.kind == KIND_ABSENT |=> !res_r.word_valid && !res_r.frame_done)
    else $error("absent bin produced a word");

endmodule
